// ===== rtl/wma4_pkg.sv =====
// ----------------------------------------------------------------------------
// wma4_pkg
// shared types and constants for the four-tap weighted moving average
// ----------------------------------------------------------------------------
package wma4_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int WEIGHT_BITS     = 7;
  localparam int TAP_COUNT       = 4;
  localparam int TAP_IDX_BITS    = 2;
  localparam int FILL_BITS       = 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                    load;
    logic                    mac;
    logic [TAP_IDX_BITS-1:0] idx;
    logic                    prep;
    logic                    div_step;
    logic                    out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // tap weights, newest first
  function automatic logic [WEIGHT_BITS-1:0] tap_weight(input logic [TAP_IDX_BITS-1:0] idx);
    logic [WEIGHT_BITS-1:0] w;
    case (idx)
      2'd0:    w = 7'd50;
      2'd1:    w = 7'd25;
      2'd2:    w = 7'd15;
      default: w = 7'd10;
    endcase
    return w;
  endfunction

  // sum of the weights of the filled taps
  function automatic logic [WEIGHT_BITS-1:0] weight_total(input logic [FILL_BITS-1:0] fill);
    logic [WEIGHT_BITS-1:0] t;
    case (fill)
      3'd1:    t = 7'd50;
      3'd2:    t = 7'd75;
      3'd3:    t = 7'd90;
      3'd4:    t = 7'd100;
      default: t = 7'd1;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/weighted_moving_average_4tap_unit.sv =====
// ----------------------------------------------------------------------------
// weighted_moving_average_4tap_unit
// four-tap weighted moving average (weights 50/25/15/10) of signed samples
// ----------------------------------------------------------------------------
// usage:
//   samples enter on the s_ channel, one average leaves on the m_ channel
//   for every sample. the newest four samples are weighted 50, 25, 15, 10;
//   while fewer than four have been seen the filled taps are divided by
//   50, 75 or 90 instead of 100, truncating toward zero.
// sequence:
//   after a sample transaction the block steps through the four taps
//   (one multiply-accumulate each), takes the magnitude and runs a
//   restoring divider (one quotient bit per step); the next sample is
//   taken only once the average has been handed to the output register.
// reset:
//   rst clears the history, the fill count and the output valid.
// stall:
//   the result sits in an output register; if it is still held when the
//   next result is ready the block waits and s_tready stays low.
// ----------------------------------------------------------------------------
module weighted_moving_average_4tap_unit import wma4_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample_in
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata   // average_out
);

  localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int MAG_BITS  = SAMPLE_BITS + 6;

  cmd_t                   cmd;
  status_t                status;
  logic [SAMPLE_BITS-1:0] average_out;

  wma4_ctrl #(
    .MAG_BITS (MAG_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wma4_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sample_in   (s_tdata[SAMPLE_BITS-1:0]),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .average_out (average_out)
  );

  assign m_tdata = DATA_BITS'(average_out);

  // one sample at a time: no second transaction right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a sample is in progress");

  // a result is only written into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten");

  // output valid only rises after the sequencer hands off a result
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.out_load))
    else $error("output valid without a finished result");

endmodule

// ===== rtl/wma4_ctrl.sv =====
// ----------------------------------------------------------------------------
// wma4_ctrl
// sequencer: accepts a sample, steps the taps, runs the divider, hands off
// ----------------------------------------------------------------------------
module wma4_ctrl import wma4_pkg::*; #(
  parameter int MAG_BITS = SAMPLE_BITS_DEF + 6
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam int CNT_BITS = $clog2(MAG_BITS);

  state_t              state, state_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (s_tvalid) state_next = S_MAC;
      end
      S_MAC: begin
        if (cnt == CNT_BITS'(TAP_COUNT - 1)) begin
          state_next = S_PREP;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_PREP: begin
        state_next = S_DIV;
        cnt_next   = '0;
      end
      S_DIV: begin
        if (cnt == CNT_BITS'(MAG_BITS - 1)) begin
          state_next = S_DONE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DONE: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    cmd.idx  = cnt[TAP_IDX_BITS-1:0];
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_MAC:   cmd.mac      = 1'b1;
      S_PREP:  cmd.prep     = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_DONE:  cmd.out_load = status.out_free;
      default: cmd          = '0;
    endcase
  end

endmodule

// ===== rtl/wma4_datapath.sv =====
// ----------------------------------------------------------------------------
// wma4_datapath
// tap history, multiply-accumulate, restoring divider and output register
// ----------------------------------------------------------------------------
module wma4_datapath import wma4_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [SAMPLE_BITS-1:0] average_out
);

  // |sum| <= 100 * 2^(SAMPLE_BITS-1) < 2^(SAMPLE_BITS+6)
  localparam int ACC_BITS = SAMPLE_BITS + 7;
  localparam int MAG_BITS = SAMPLE_BITS + 6;
  localparam int REM_BITS = WEIGHT_BITS + 2;

  logic signed [SAMPLE_BITS-1:0] history [TAP_COUNT-1];
  logic signed [SAMPLE_BITS-1:0] taps [TAP_COUNT];
  logic [FILL_BITS-1:0]          fill_count, fill_next;
  logic signed [ACC_BITS-1:0]    acc;
  logic [WEIGHT_BITS-1:0]        divisor;
  logic [WEIGHT_BITS-1:0]        rem;
  logic [MAG_BITS-1:0]           dvd;
  logic                          neg;

  logic signed [ACC_BITS-1:0]    product;
  logic [REM_BITS-1:0]           rem_shift;
  logic [REM_BITS-1:0]           diff;
  logic [MAG_BITS-1:0]           quot_signed;

  assign fill_next = (fill_count == FILL_BITS'(TAP_COUNT)) ? fill_count : fill_count + 1'b1;

  assign product = ACC_BITS'(taps[cmd.idx]) *
                   signed'({{(ACC_BITS-WEIGHT_BITS){1'b0}}, tap_weight(cmd.idx)});

  assign rem_shift = {1'b0, rem, dvd[MAG_BITS-1]};
  assign diff      = rem_shift - {2'b00, divisor};

  assign quot_signed = neg ? (~dvd + 1'b1) : dvd;

  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      history[0] <= '0;
      history[1] <= '0;
      history[2] <= '0;
      fill_count <= '0;
    end else if (cmd.load) begin
      history[0] <= signed'(sample_in);
      history[1] <= history[0];
      history[2] <= history[1];
      fill_count <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      taps[0] <= signed'(sample_in);
      taps[1] <= history[0];
      taps[2] <= history[1];
      taps[3] <= history[2];
      acc     <= '0;
      divisor <= weight_total(fill_next);
    end else if (cmd.mac) begin
      // only filled taps contribute
      if ({1'b0, cmd.idx} < fill_count) acc <= acc + product;
    end
    if (cmd.prep) begin
      neg <= acc[ACC_BITS-1];
      dvd <= acc[ACC_BITS-1] ? MAG_BITS'(-acc) : MAG_BITS'(acc);
      rem <= '0;
    end else if (cmd.div_step) begin
      // one quotient bit per cycle, shifted into the dividend's low end
      if (!diff[REM_BITS-1]) begin
        rem <= diff[WEIGHT_BITS-1:0];
        dvd <= {dvd[MAG_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_shift[WEIGHT_BITS-1:0];
        dvd <= {dvd[MAG_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) average_out <= quot_signed[SAMPLE_BITS-1:0];
  end

endmodule

// ===== tb/sv/weighted_moving_average_4tap_unit_test.sv =====
// ----------------------------------------------------------------------------
// weighted_moving_average_4tap_unit_test
// self-checking bench for the four-tap weighted moving average
// ----------------------------------------------------------------------------
// a short table of directed samples covers warm-up divisors, truncation
// toward zero and full-scale windows, then about 700 random samples follow.
// every average is compared against a local model of the tap history and
// fill count, or against the table value where the row is fixed; random
// gaps on the sample side and random stalls on the average side land on
// all phases of the divider.
module weighted_moving_average_4tap_unit_test import wma4_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int BUS_W = ((SW + 7) / 8) * 8;
  localparam int RANDOM_SAMPLES = 700;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 2 * (SW + 13);

  localparam longint TAP_WEIGHT [4] = '{50, 25, 15, 10};
  localparam longint FILL_DIVISOR [5] = '{1, 50, 75, 90, 100};

  localparam logic [SW-1:0] MAX_SAMPLE = 16'h7fff;
  localparam logic [SW-1:0] MIN_SAMPLE = 16'h8000;

  // fixed = 1 means the average column holds the expected value
  typedef struct packed {
    logic          fixed;
    logic [SW-1:0] sample;
    logic [SW-1:0] average;
  } sample_row_t;

  localparam int DIRECTED_ROWS = 24;
  localparam sample_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b1, 16'h0001, 16'h0001},    // first tap alone, divided by 50
    '{1'b1, 16'hffff, 16'h0000},    // -25/75 rounds toward zero
    '{1'b0, 16'h0003, 16'h0000},
    '{1'b0, MIN_SAMPLE, 16'h0000},  // window just filled
    '{1'b0, MAX_SAMPLE, 16'h0000},
    '{1'b0, MAX_SAMPLE, 16'h0000},
    '{1'b0, MAX_SAMPLE, 16'h0000},
    '{1'b1, MAX_SAMPLE, MAX_SAMPLE},
    '{1'b0, MIN_SAMPLE, 16'h0000},
    '{1'b0, MIN_SAMPLE, 16'h0000},
    '{1'b0, MIN_SAMPLE, 16'h0000},
    '{1'b1, MIN_SAMPLE, MIN_SAMPLE},
    '{1'b0, 16'h0000, 16'h0000},
    '{1'b0, 16'h0000, 16'h0000},
    '{1'b0, 16'h0000, 16'h0000},
    '{1'b1, 16'h0000, 16'h0000},
    '{1'b0, 16'h0002, 16'h0000},
    '{1'b0, 16'hffff, 16'h0000},
    '{1'b0, 16'h0001, 16'h0000},
    '{1'b0, 16'hfffe, 16'h0000},
    '{1'b0, 16'h5555, 16'h0000},
    '{1'b0, 16'haaaa, 16'h0000},
    '{1'b0, 16'h0001, 16'h0000},
    '{1'b0, 16'hfffe, 16'h0000}
  };

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [BUS_W-1:0] s_tdata;   // sample_in
  logic             m_tvalid;
  logic             m_tready;
  logic [BUS_W-1:0] m_tdata;   // average_out

  weighted_moving_average_4tap_unit #(
    .SAMPLE_BITS(SW)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // model state: previous samples, newest first, and filled tap count
  logic signed [SW-1:0] past_samples [3] = '{default: '0};
  int unsigned          taps_filled = 0;

  logic [SW-1:0] pending_averages [$];
  int            mismatch_count = 0;
  int unsigned   cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [SW-1:0] next_average(input logic [SW-1:0] sample);
    longint window [4];
    longint acc;
    window[0] = longint'($signed(sample));
    for (int k = 1; k < 4; k++) window[k] = longint'(past_samples[k-1]);
    past_samples[2] = past_samples[1];
    past_samples[1] = past_samples[0];
    past_samples[0] = $signed(sample);
    if (taps_filled < 4) taps_filled++;
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      if (k < taps_filled) acc += window[k] * TAP_WEIGHT[k];
    end
    return SW'(acc / FILL_DIVISOR[taps_filled]);
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_cycles();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return 0;
    if (pick < 7) return $urandom_range(1, 3);
    if (pick < 9) return $urandom_range(4, 30);
    return $urandom_range(31, 120);
  endfunction

  function automatic logic [SW-1:0] random_sample(input logic [SW-1:0] last_sample);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: return SW'($urandom_range(0, 65535));
      4, 5:       return SW'(int'($urandom_range(0, 16)) - 8);
      6: begin
        case ($urandom_range(0, 3))
          0:       return MAX_SAMPLE;
          1:       return MIN_SAMPLE;
          2:       return '0;
          default: return '1;
        endcase
      end
      7:          return MAX_SAMPLE - SW'($urandom_range(0, 200));
      8:          return MIN_SAMPLE + SW'($urandom_range(0, 200));
      default:    return last_sample;  // runs of equal samples
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [SW-1:0] got,
                               input logic [SW-1:0] want);
    $display("mismatch at cycle %0d: %s, got %h expected %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // holds the sample on the bus until a transaction takes it
  task automatic send_sample(input logic [SW-1:0] sample, input logic fixed,
                             input logic [SW-1:0] fixed_average);
    logic [SW-1:0] predicted;
    s_tvalid <= 1'b1;
    s_tdata  <= BUS_W'(sample);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = next_average(sample);
    pending_averages.push_back(fixed ? fixed_average : predicted);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= BUS_W'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  initial begin
    logic [SW-1:0] last_sample;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      idle_sender(idle_cycles());
      send_sample(DIRECTED[r].sample, DIRECTED[r].fixed, DIRECTED[r].average);
    end

    last_sample = '0;
    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      idle_sender(idle_cycles());
      last_sample = random_sample(last_sample);
      send_sample(last_sample, 1'b0, '0);
    end
    s_tvalid <= 1'b0;

    while (pending_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // average side backpressure: open stretches broken by random stalls
  initial begin
    int unsigned stall;
    forever begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(100, 300)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
      stall = idle_cycles();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    logic [SW-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_averages.size() == 0) begin
        flag_mismatch("average with no sample pending", m_tdata[SW-1:0], 'x);
      end else begin
        want = pending_averages.pop_front();
        if (m_tdata[SW-1:0] !== want) flag_mismatch("average_out", m_tdata[SW-1:0], want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
rtl/wma4_pkg.sv
rtl/wma4_ctrl.sv
rtl/wma4_datapath.sv
rtl/weighted_moving_average_4tap_unit.sv
tb/sv/weighted_moving_average_4tap_unit_test.sv
